// File: rtl/core/rlr_pkg.sv
// Shared types and codes for the recency list with rank.
package rlr_pkg;

	localparam int FIELD_W = 9;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [FIELD_W-1:0] LIMIT_RESET = 9'd256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_SHIFT,
		ST_PUT,
		ST_DONE
	} state_t;

endpackage

// File: rtl/core/rlr_mem.sv
// Key store: one write port, one read port with registered read data.
module rlr_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/recency_list_with_rank_top.sv
// Recency list with rank: sequencer, list pointers and output register.
//
// Input channel (in_valid/in_ready) carries op and key. op add refreshes a
// present key to the newest end, or appends a new key and evicts the oldest
// entries down to history_limit. op query reports found and rank (1 = newest).
// Every transfer yields exactly one result on the output channel
// (out_valid/out_ready): found, rank and entry_count after the operation.
// The configuration channel (cfg_valid/cfg_ready) writes history_limit; it is
// always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. Keys live in a circular buffer in
// one memory; a scan reads one entry per cycle and compares it with the
// incoming key, and a refresh closes the gap by copying one entry per cycle
// through the same read and write ports.
// One item is in work at a time; in_ready is low until the result is loaded
// into the output register; the next transfer can follow in the next cycle.
// Reset empties the list and sets history_limit to 256; no clearing pass.
// A stalled receiver holds the result in the output register; the block
// takes the next item but holds its result until the first one is transferred.
module recency_list_with_rank_top #(
	parameter int DEPTH     = 256,
	parameter int KEY_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rlr_pkg::FIELD_W-1:0]   history_limit,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [KEY_WIDTH-1:0]          key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [rlr_pkg::FIELD_W-1:0]   rank,
	output logic [rlr_pkg::FIELD_W-1:0]   entry_count
);

	import rlr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > FIELD_W) ? CW : FIELD_W;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] idx);
		logic [CW:0] sum;
		sum = (CW+1)'(h) + (CW+1)'(idx);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return AW'(sum);
	endfunction

	state_t state_q, state_d;

	logic [FIELD_W-1:0]   limit_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        head_q;
	logic                 op_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic                 found_q;
	logic [CW-1:0]        pos_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        put_idx_q;
	logic                 cv_s1;
	logic [CW-1:0]        cidx_s1;

	logic                 ov_q;
	logic                 found_out_q;
	logic [FIELD_W-1:0]   rank_out_q;
	logic [FIELD_W-1:0]   count_out_q;

	logic                 in_xfer;
	logic                 scan;
	logic                 issue;
	logic                 hit;
	logic                 last;
	logic                 load_out;
	logic [CW-1:0]        lim_c;
	logic [CW:0]          n_c;
	logic [CW:0]          drop_c;
	logic                 empty_c;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [KEY_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [KEY_WIDTH-1:0] mem_rdata;

	rlr_mem #(
		.DEPTH(DEPTH),
		.WIDTH(KEY_WIDTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_xfer = in_valid && in_ready;
	assign scan    = (state_q == ST_SEARCH) || (state_q == ST_SHIFT);
	assign issue   = scan && (idx_q < count_q);
	assign hit     = cv_s1 && (mem_rdata == key_q);
	assign last    = cv_s1 && (cidx_s1 == count_q - CW'(1));

	assign lim_c   = (LW'(limit_q) > LW'(DEPTH)) ? CW'(DEPTH) : CW'(limit_q);
	assign n_c     = (CW+1)'(count_q) + (CW+1)'(1);
	assign drop_c  = (n_c > (CW+1)'(lim_c)) ? (n_c - (CW+1)'(lim_c)) : '0;
	assign empty_c = (drop_c >= n_c);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (count_q == '0) ? ST_DECIDE : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit || last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (op_q == OP_QUERY) begin
					state_d = ST_DONE;
				end else if (found_q) begin
					state_d = (pos_q + CW'(1) < count_q) ? ST_SHIFT : ST_DONE;
				end else begin
					state_d = empty_c ? ST_DONE : ST_PUT;
				end
			end
			ST_SHIFT: begin
				if (last) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
		load_out  = (state_q == ST_DONE) && (!ov_q || out_ready);
		mem_raddr = phys(head_q, idx_q);
		mem_we    = 1'b0;
		mem_waddr = phys(head_q, put_idx_q);
		mem_wdata = key_q;
		case (state_q)
			ST_SHIFT: begin
				mem_we    = cv_s1;
				mem_waddr = phys(head_q, cidx_s1 - CW'(1));
				mem_wdata = mem_rdata;
			end
			ST_PUT: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_q <= LIMIT_RESET;
			count_q <= '0;
			head_q  <= '0;
			cv_s1   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cv_s1   <= issue;
			if (cfg_valid && cfg_ready) begin
				limit_q <= history_limit;
			end
			if (state_q == ST_DECIDE && op_q == OP_ADD && !found_q) begin
				if (empty_c) begin
					count_q <= '0;
				end else begin
					head_q  <= phys(head_q, CW'(drop_c));
					count_q <= count_q - CW'(drop_c) + CW'(1);
				end
			end
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cidx_s1 <= idx_q;
		if (issue) begin
			idx_q <= idx_q + CW'(1);
		end
		case (state_q)
			ST_IDLE: begin
				op_q    <= op;
				key_q   <= key;
				found_q <= 1'b0;
				idx_q   <= '0;
			end
			ST_SEARCH: begin
				if (hit) begin
					found_q <= 1'b1;
					pos_q   <= cidx_s1;
				end
			end
			ST_DECIDE: begin
				idx_q <= pos_q + CW'(1);
				if (found_q) begin
					put_idx_q <= count_q - CW'(1);
				end else begin
					put_idx_q <= count_q - CW'(drop_c);
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			found_out_q <= found_q;
			rank_out_q  <= (op_q == OP_QUERY && found_q) ? FIELD_W'(count_q - pos_q) : '0;
			count_out_q <= FIELD_W'(count_q);
		end
	end

	assign out_valid   = ov_q;
	assign found       = found_out_q;
	assign rank        = rank_out_q;
	assign entry_count = count_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_scan_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(scan && cv_s1) |-> (cidx_s1 < count_q))
		else $error("scan read beyond the list");

	a_shift_above_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && cv_s1) |-> (cidx_s1 > pos_q))
		else $error("shift writes below the gap");

	a_new_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT && op_q == OP_ADD && !found_q) |-> (count_q <= lim_c))
		else $error("new key left the list above its limit");

	a_refresh_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && (op_q == OP_QUERY || found_q)) |=> $stable(count_q))
		else $error("count changed on query or refresh");

endmodule

// File: sim/tb_recency_list_with_rank_top.sv
// Self-checking testbench for the recency list with rank: directed and random phases.
`timescale 1ns / 1ps

module tb_recency_list_with_rank_top;
	import rlr_pkg::*;

	localparam int LIST_DEPTH     = 256;
	localparam int TAG_W          = 32;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 600;

	typedef struct packed {
		logic               found;
		logic [FIELD_W-1:0] rank;
		logic [FIELD_W-1:0] entry_count;
	} recency_answer_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [FIELD_W-1:0] cfg_limit;
	logic               in_valid;
	logic               in_ready;
	logic               in_op;
	logic [TAG_W-1:0]   in_key;
	logic               out_valid;
	logic               out_ready;
	logic               out_found;
	logic [FIELD_W-1:0] out_rank;
	logic [FIELD_W-1:0] out_entry_count;

	logic [TAG_W-1:0] list_keys [LIST_DEPTH];
	int               list_count;
	int               limit_q;
	recency_answer_t  recency_answers [$];
	logic [TAG_W-1:0] key_pool [$];
	int               fault_count;
	int               idle_cycles;
	bit               steady_flow;

	recency_list_with_rank_top #(
		.DEPTH     (LIST_DEPTH),
		.KEY_WIDTH (TAG_W)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.history_limit (cfg_limit),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (in_op),
		.key           (in_key),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (out_found),
		.rank          (out_rank),
		.entry_count   (out_entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_fault(input string msg);
		fault_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic update_recency_list(input logic op_i, input logic [TAG_W-1:0] key_i);
		int              pos;
		int              lim;
		int              n;
		int              drop;
		recency_answer_t ans;
		pos = -1;
		for (int i = 0; i < list_count; i++)
			if (pos < 0 && list_keys[i] == key_i)
				pos = i;
		ans.found = (pos >= 0);
		ans.rank  = '0;
		if (op_i == OP_QUERY) begin
			if (pos >= 0)
				ans.rank = FIELD_W'(list_count - pos);
		end else if (pos >= 0) begin
			for (int i = pos; i < list_count - 1; i++)
				list_keys[i] = list_keys[i + 1];
			list_keys[list_count - 1] = key_i;
		end else begin
			lim  = (limit_q > LIST_DEPTH) ? LIST_DEPTH : limit_q;
			n    = list_count + 1;
			drop = (n > lim) ? n - lim : 0;
			if (drop >= n) begin
				list_count = 0;
			end else begin
				if (drop > 0) begin
					for (int i = 0; i < list_count - drop; i++)
						list_keys[i] = list_keys[i + drop];
					list_count -= drop;
				end
				if (list_count < LIST_DEPTH) begin
					list_keys[list_count] = key_i;
					list_count++;
				end
			end
		end
		ans.entry_count = FIELD_W'(list_count);
		recency_answers.insert(recency_answers.size(), ans);
	endtask

	task automatic send_item(input logic op_i, input logic [TAG_W-1:0] key_i);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_op    <= op_i;
		in_key   <= key_i;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		update_recency_list(op_i, key_i);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (recency_answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input int value);
		settle();
		cfg_valid <= 1'b1;
		cfg_limit <= FIELD_W'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		limit_q = value & 'h1FF;
		cfg_valid <= 1'b0;
	endtask

	task automatic new_pool(input int n);
		key_pool.delete();
		key_pool.insert(key_pool.size(), '0);
		key_pool.insert(key_pool.size(), '1);
		for (int i = 2; i < n; i++)
			key_pool.insert(key_pool.size(), $urandom());
	endtask

	task automatic run_mix(input int n, input int add_pct, input int fresh_pct);
		logic             op_i;
		logic [TAG_W-1:0] key_i;
		for (int i = 0; i < n; i++) begin
			steady_flow = ((i % 64) < 12);
			op_i = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_QUERY;
			if (key_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
				key_i = $urandom();
				if (op_i == OP_ADD)
					key_pool.insert(key_pool.size(), key_i);
			end else begin
				key_i = key_pool[$urandom_range(0, key_pool.size() - 1)];
			end
			send_item(op_i, key_i);
		end
		steady_flow = 1'b0;
	endtask

	task automatic test_directed();
		send_item(OP_QUERY, 32'h0000_0000);
		send_item(OP_ADD,   32'h0000_0000);
		send_item(OP_ADD,   32'hFFFF_FFFF);
		send_item(OP_QUERY, 32'hFFFF_FFFF);
		send_item(OP_QUERY, 32'h0000_0000);
		send_item(OP_ADD,   32'h0000_0000);
		send_item(OP_QUERY, 32'h0000_0000);
		send_item(OP_ADD,   32'h8000_0001);
		send_item(OP_ADD,   32'h7FFF_FFFE);
		send_item(OP_ADD,   32'hFFFF_FFFF);
		send_item(OP_QUERY, 32'h7FFF_FFFE);
		// lower the limit: no trim until a new key arrives
		write_limit(2);
		send_item(OP_QUERY, 32'h0000_0000);
		send_item(OP_ADD,   32'h0000_0000);
		send_item(OP_ADD,   32'h1234_5678);
		send_item(OP_QUERY, 32'h8000_0001);
		// zero limit: refresh keeps, new key empties
		write_limit(0);
		send_item(OP_ADD,   32'h1234_5678);
		send_item(OP_ADD,   32'h0000_0000);
		send_item(OP_ADD,   32'h55AA_55AA);
		send_item(OP_QUERY, 32'h0000_0000);
		send_item(OP_ADD,   32'h0000_0001);
		write_limit(1);
		send_item(OP_ADD,   32'h0000_0002);
		send_item(OP_ADD,   32'h0000_0003);
		send_item(OP_QUERY, 32'h0000_0002);
		send_item(OP_QUERY, 32'h0000_0003);
		send_item(OP_ADD,   32'h0000_0003);
	endtask

	task automatic test_small_limits();
		int limits [5] = '{1, 2, 3, 5, 8};
		foreach (limits[i]) begin
			write_limit(limits[i]);
			new_pool(6);
			run_mix(70, 55, 15);
		end
	endtask

	task automatic test_fill_to_depth();
		write_limit(LIST_DEPTH);
		new_pool(0);
		run_mix(350, 85, 90);
	endtask

	task automatic test_limit_above_depth();
		write_limit(511);
		run_mix(150, 70, 50);
		// lower the limit on a full list
		write_limit(16);
		run_mix(60, 60, 30);
	endtask

	task automatic test_random_limits();
		for (int i = 0; i < 3; i++) begin
			write_limit($urandom_range(0, 511));
			new_pool(40);
			run_mix(100, 60, 20);
		end
	endtask

	initial begin
		recency_answer_t want;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (recency_answers.size() == 0) begin
					report_fault("result transfer with nothing outstanding");
				end else begin
					want = recency_answers.pop_front();
					if (out_found !== want.found)
						report_fault($sformatf("found: expected %0d got %0d",
							want.found, out_found));
					if (out_rank !== want.rank)
						report_fault($sformatf("rank: expected %0d got %0d",
							want.rank, out_rank));
					if (out_entry_count !== want.entry_count)
						report_fault($sformatf("entry_count: expected %0d got %0d",
							want.entry_count, out_entry_count));
				end
			end
			if (!steady_flow && $urandom_range(0, 199) == 0) begin
				out_ready <= 1'b0;
				@(posedge clk);
				if (out_valid && out_ready)
					report_fault("result transfer while ready was held low");
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) < 75) || steady_flow ||
					(pick_gap() == 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		fault_count  = 0;
		list_count   = 0;
		limit_q      = LIMIT_RESET;
		steady_flow  = 1'b0;
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_limit   <= '0;
		in_valid    <= 1'b0;
		in_op       <= OP_ADD;
		in_key      <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_small_limits();
		test_fill_to_depth();
		test_limit_above_depth();
		test_random_limits();
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (recency_answers.size() != 0)
			report_fault("expected results left outstanding");
		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/rlr_pkg.sv
rtl/core/rlr_mem.sv
rtl/core/recency_list_with_rank_top.sv
sim/tb_recency_list_with_rank_top.sv
